@@ rtl/fixed_point_matrix_vector_mac_assert.svh @@
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_MATRIX_VECTOR_MAC_ASSERT_SVH
`define FIXED_POINT_MATRIX_VECTOR_MAC_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define FPMV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpmv: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define FPMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpmv: next-cycle check failed");

`endif

@@ rtl/fpmv_pkg.sv @@
package fpmv_pkg;

    localparam int VALUE_W    = 16;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_LIMIT  = 64;

    localparam logic [COUNT_W-1:0]   COUNT_RESET   = 7'd64;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

    typedef enum logic [1:0] {
        CMD_MAT = 2'd0,
        CMD_VEC = 2'd1,
        CMD_RES = 2'd2,
        CMD_RUN = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        t_cmd                       cmd;
        logic [INDEX_W-1:0]         row;
        logic [INDEX_W-1:0]         col;
        logic signed [VALUE_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  result_value;
        logic [INDEX_W-1:0]         result_row;
        logic                       last;
    } t_out;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

@@ rtl/fpmv_ram.sv @@
module fpmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fpmv_mac.sv @@
module fpmv_mac #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  fpmv_pkg::t_mac_ctl                      i_ctl,
    input  logic signed [fpmv_pkg::VALUE_W-1:0]     i_a,
    input  logic signed [fpmv_pkg::VALUE_W-1:0]     i_b,
    output logic signed [fpmv_pkg::VALUE_W-1:0]     o_acc,
    output logic                                    o_pending
);

    logic signed [2*fpmv_pkg::VALUE_W-1:0] r_prod;
    logic                                  r_prod_vld;
    logic signed [fpmv_pkg::VALUE_W-1:0]   r_acc;
    logic signed [fpmv_pkg::VALUE_W-1:0]   n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (r_prod_vld) begin
            // scale back, keep low bits; the sum wraps
            n_acc = r_acc + fpmv_pkg::VALUE_W'(r_prod >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.valid;
        end
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
        r_acc <= n_acc;
    end

    assign o_acc     = r_acc;
    assign o_pending = r_prod_vld;

endmodule

@@ rtl/fixed_point_matrix_vector_mac.sv @@
// Load items (matrix, vector, initial result entry) leave busy low.
// A compute item runs on one shared multiply-accumulate unit, fed one column per cycle
// within a row from the matrix and vector RAMs.
// Each row's result strobes once its last product is accumulated; busy falls with the last.
// Results cannot be stalled. Synchronous active-low reset clears the sequencer and sets
// both counts to 64; the stores are undefined until written.
module fixed_point_matrix_vector_mac #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  fpmv_pkg::t_in                       i_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpmv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpmv_pkg::COUNT_W-1:0]        i_cfg_data,
    output logic                                o_strobe,
    output fpmv_pkg::t_out                      o_result
);

    localparam int AW      = $clog2(MAX_DIM);
    localparam int MAW     = $clog2(MAX_DIM * MAX_DIM);
    localparam int CW_MIN  = $clog2(MAX_DIM + 1);
    localparam int EW      = (CW_MIN > fpmv_pkg::COUNT_W) ? CW_MIN : fpmv_pkg::COUNT_W;
    localparam int ROW_CAP = (MAX_DIM < fpmv_pkg::ROW_LIMIT) ? MAX_DIM : fpmv_pkg::ROW_LIMIT;
    localparam int VW      = fpmv_pkg::VALUE_W;

    fpmv_pkg::t_state r_state, n_state;
    logic [fpmv_pkg::COUNT_W-1:0] r_row_count, r_col_count;
    logic [AW-1:0]                r_col, n_col;
    logic [fpmv_pkg::INDEX_W-1:0] r_row, n_row;
    logic [MAW-1:0]               r_base, n_base;
    logic                         r_rd_vld;
    logic                         r_strobe, n_strobe;
    fpmv_pkg::t_out               r_out, n_out;

    logic                         accept;
    logic                         issue;
    logic                         row_start;
    logic                         wb;
    logic [fpmv_pkg::COUNT_W-1:0] rows_eff;
    logic [EW-1:0]                cols_eff;
    logic                         cols_zero;
    logic                         col_last;
    logic                         row_last;
    logic                         row_ok, col_ok;

    logic                         mat_we, vec_we, res_we;
    logic [MAW-1:0]               mat_waddr;
    logic [AW-1:0]                res_waddr;
    logic [VW-1:0]                res_wdata;
    logic [VW-1:0]                mat_q, vec_q, res_q;
    logic signed [VW-1:0]         acc;
    logic                         mac_pending;
    logic [VW-1:0]                sum;
    fpmv_pkg::t_mac_ctl           mac_ctl;

    assign accept      = start && !busy;
    assign busy        = (r_state != fpmv_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign rows_eff  = (r_row_count > fpmv_pkg::COUNT_W'(ROW_CAP))
                     ? fpmv_pkg::COUNT_W'(ROW_CAP) : r_row_count;
    assign cols_eff  = (EW'(r_col_count) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(r_col_count);
    assign cols_zero = (cols_eff == '0);
    assign col_last  = (EW'(r_col) == cols_eff - EW'(1));
    assign row_last  = (fpmv_pkg::COUNT_W'(r_row) + fpmv_pkg::COUNT_W'(1) == rows_eff);

    assign row_ok = (32'(i_item.row) < MAX_DIM);
    assign col_ok = (32'(i_item.col) < MAX_DIM);

    assign sum = res_q + acc;

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_base    = r_base;
        n_strobe  = 1'b0;
        n_out     = r_out;
        issue     = 1'b0;
        row_start = 1'b0;
        wb        = 1'b0;
        case (r_state)
            fpmv_pkg::ST_IDLE: begin
                if (accept && i_item.cmd == fpmv_pkg::CMD_RUN && rows_eff != '0) begin
                    n_state = fpmv_pkg::ST_MAC;
                    n_col   = '0;
                    n_row   = '0;
                    n_base  = '0;
                end
            end
            fpmv_pkg::ST_MAC: begin
                row_start = (r_col == '0);
                issue     = !cols_zero;
                if (cols_zero || col_last) begin
                    n_state = fpmv_pkg::ST_DRAIN;
                    n_col   = '0;
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
            fpmv_pkg::ST_DRAIN: begin
                // emit once every product of the row has landed
                if (!r_rd_vld && !mac_pending) begin
                    wb                 = 1'b1;
                    n_strobe           = 1'b1;
                    n_out.result_value = sum;
                    n_out.result_row   = r_row;
                    n_out.last         = row_last;
                    if (row_last) begin
                        n_state = fpmv_pkg::ST_IDLE;
                    end else begin
                        n_state = fpmv_pkg::ST_MAC;
                        n_row   = r_row + fpmv_pkg::INDEX_W'(1);
                        n_base  = r_base + MAW'(MAX_DIM);
                    end
                end
            end
            default: begin
                n_state = fpmv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpmv_pkg::ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_strobe    <= 1'b0;
            r_row_count <= fpmv_pkg::COUNT_RESET;
            r_col_count <= fpmv_pkg::COUNT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r_strobe <= n_strobe;
            r_col    <= n_col;
            r_row    <= n_row;
            r_base   <= n_base;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == fpmv_pkg::CFG_ROW_COUNT) begin
                    r_row_count <= i_cfg_data;
                end else if (i_cfg_index == fpmv_pkg::CFG_COL_COUNT) begin
                    r_col_count <= i_cfg_data;
                end
            end
        end
        r_out <= n_out;
    end

    assign mat_we    = accept && i_item.cmd == fpmv_pkg::CMD_MAT && row_ok && col_ok;
    assign mat_waddr = MAW'(32'(i_item.row) * MAX_DIM + 32'(i_item.col));
    assign vec_we    = accept && i_item.cmd == fpmv_pkg::CMD_VEC && col_ok;
    assign res_we    = (accept && i_item.cmd == fpmv_pkg::CMD_RES && row_ok) || wb;
    assign res_waddr = wb ? AW'(r_row) : AW'(i_item.row);
    assign res_wdata = wb ? sum : i_item.value;

    fpmv_ram #(.WIDTH(VW), .DEPTH(MAX_DIM * MAX_DIM)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (i_item.value),
        .i_re    (issue),
        .i_raddr (r_base + MAW'(r_col)),
        .o_rdata (mat_q)
    );

    fpmv_ram #(.WIDTH(VW), .DEPTH(MAX_DIM)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (AW'(i_item.col)),
        .i_wdata (i_item.value),
        .i_re    (issue),
        .i_raddr (r_col),
        .o_rdata (vec_q)
    );

    // read the row's old result at row start; the port holds it until write-back
    fpmv_ram #(.WIDTH(VW), .DEPTH(MAX_DIM)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_re    (row_start),
        .i_raddr (AW'(r_row)),
        .o_rdata (res_q)
    );

    assign mac_ctl.clear = row_start;
    assign mac_ctl.valid = r_rd_vld;

    fpmv_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_a       (mat_q),
        .i_b       (vec_q),
        .o_acc     (acc),
        .o_pending (mac_pending)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ rtl/fpmv_chk.sv @@
`include "fixed_point_matrix_vector_mac_assert.svh"

module fpmv_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  fpmv_pkg::t_in   i_item,
    input  logic            o_strobe,
    input  fpmv_pkg::t_out  o_result
);

    // a result only follows a cycle of compute work
    `FPMV_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))

    // load items finish in their own cycle
    `FPMV_ASSERT_NEXT(a_load_no_busy, i_clk, i_rst_n,
        start && !busy && i_item.cmd != fpmv_pkg::CMD_RUN, !busy)

    // a compute run ends exactly with its marked last result
    `FPMV_ASSERT_NOW(a_end_with_last, i_clk, i_rst_n, $fell(busy), o_strobe && o_result.last)

    // more rows follow an unmarked result
    `FPMV_ASSERT_NOW(a_more_rows, i_clk, i_rst_n, o_strobe && !o_result.last, busy)

endmodule

bind fixed_point_matrix_vector_mac fpmv_chk u_fpmv_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
